// ===== design/mst_pkg.sv =====
package mst_pkg;

	localparam int TICK_W      = 16;
	localparam int ID_W        = 8;
	localparam int MAX_RESULTS = 16;
	localparam int FIRE_W      = $clog2(MAX_RESULTS + 1);

	typedef enum logic [1:0] {
		REQ_ADD    = 2'd0,
		REQ_CANCEL = 2'd1,
		REQ_WAIT   = 2'd2,
		REQ_TICK   = 2'd3
	} req_type_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_INVALID  = 3'd1,
		ST_FULL     = 3'd2,
		ST_CANCELED = 3'd3,
		ST_BUSY     = 3'd4,
		ST_PENDING  = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		MODE_RUNNING  = 2'd0,
		MODE_OVER     = 2'd1,
		MODE_CANCELED = 2'd2
	} mode_t;

	typedef struct packed {
		req_type_t         req_type;
		logic [TICK_W-1:0] seconds;
		logic [ID_W-1:0]   timer_id;
	} req_t;

	typedef struct packed {
		status_t         status;
		logic [ID_W-1:0] slot;
		logic            fired;
		logic            last;
	} rsp_t;

	typedef struct packed {
		mode_t             mode;
		logic [TICK_W-1:0] ticks;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD,
		S_CHK_RD,
		S_CHK_EX,
		S_TICK,
		S_TICK_END,
		S_TICK_FLUSH
	} state_t;

	typedef struct packed {
		logic load;
		logic idx_inc;
		logic add_claim;
		logic add_full;
		logic chk_bad;
		logic chk_read;
		logic chk_exec;
		logic tick_rd;
		logic tick_flush;
	} ctrl_cmd_t;

	typedef struct packed {
		logic idx_last;
		logic idx_free;
		logic id_ok;
	} dp_stat_t;

endpackage

// ===== design/multi_slot_timer_table.sv =====
// Channel   Handshake                Payload  Notes
// request   start & !busy            req      add / cancel / wait / tick
// response  rsp_valid (1-cycle beat) rsp      one beat per result, last marks end
//
// Add scans slots from 0 and claims the lowest free slot, or answers full after the last.
// Cancel and wait check the id, then read the table and act on it; a tick walks the
// single-port slot memory one slot per cycle, then evaluates the last slot and flushes.
// Reset clears the used bits, so the table is empty at once; no clearing pass.
// The response side cannot stall: every beat is shown for exactly one cycle.
module multi_slot_timer_table
	import mst_pkg::*;
#(
	parameter int NUM_TIMERS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output rsp_t rsp,
	output logic rsp_valid
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	// sequencer: one item at a time, walks slots for add and tick
	mst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req.req_type),
		.stat     (stat),
		.cmd      (cmd),
		.busy     (busy)
	);

	// slot memory, used bits, fire hold register and result beat register
	mst_dpath #(
		.NUM_TIMERS (NUM_TIMERS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.stat      (stat),
		.rsp       (rsp),
		.rsp_valid (rsp_valid)
	);

endmodule

// ===== design/mst_ctrl.sv =====
module mst_ctrl
	import mst_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  req_type_t req_type,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd,
	output logic      busy
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					case (req_type)
						REQ_ADD:    state_d = S_ADD;
						REQ_CANCEL: state_d = S_CHK_RD;
						REQ_WAIT:   state_d = S_CHK_RD;
						default:    state_d = S_TICK;
					endcase
				end
			end
			S_ADD: begin
				if (stat.idx_free) begin
					cmd.add_claim = 1'b1;
					state_d       = S_IDLE;
				end else if (stat.idx_last) begin
					cmd.add_full = 1'b1;
					state_d      = S_IDLE;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			S_CHK_RD: begin
				if (!stat.id_ok) begin
					cmd.chk_bad = 1'b1;
					state_d     = S_IDLE;
				end else begin
					cmd.chk_read = 1'b1;
					state_d      = S_CHK_EX;
				end
			end
			S_CHK_EX: begin
				cmd.chk_exec = 1'b1;
				state_d      = S_IDLE;
			end
			S_TICK: begin
				cmd.tick_rd = 1'b1;
				if (stat.idx_last) begin
					state_d = S_TICK_END;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			S_TICK_END: begin
				// last slot is evaluated in the datapath this cycle
				state_d = S_TICK_FLUSH;
			end
			S_TICK_FLUSH: begin
				cmd.tick_flush = 1'b1;
				state_d        = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== design/mst_dpath.sv =====
module mst_dpath
	import mst_pkg::*;
#(
	parameter int NUM_TIMERS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  req_t      req,
	input  ctrl_cmd_t cmd,
	output dp_stat_t  stat,
	output rsp_t      rsp,
	output logic      rsp_valid
);

	localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

	req_t              req_q;
	logic [IW-1:0]     idx_q;
	logic [NUM_TIMERS-1:0] used_q;
	entry_t            mem [NUM_TIMERS];
	entry_t            rd_data_s1;
	logic              tick_s1;
	logic [IW-1:0]     idx_s1;
	logic [FIRE_W-1:0] fire_cnt_q;
	logic              hold_valid_q;
	logic [IW-1:0]     hold_slot_q;
	rsp_t              rsp_q;
	logic              rsp_valid_q;

	logic [IW-1:0] id_idx;
	logic          id_in;
	logic [IW-1:0] rd_addr;
	logic          rd_en;
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	entry_t        wr_data;
	logic          running;
	logic          expire;
	logic          fire;
	logic          emit;
	rsp_t          emit_rsp;

	assign id_idx = req_q.timer_id[IW-1:0];
	assign id_in  = ({1'b0, req_q.timer_id} < (ID_W+1)'(NUM_TIMERS));

	assign stat.id_ok    = id_in && used_q[id_idx];
	assign stat.idx_last = (idx_q == IW'(NUM_TIMERS - 1));
	assign stat.idx_free = !used_q[idx_q];

	assign rd_addr = cmd.chk_read ? id_idx : idx_q;
	assign rd_en   = cmd.chk_read | cmd.tick_rd;

	// tick evaluation of the slot read in the previous cycle
	assign running = tick_s1 && used_q[idx_s1] && (rd_data_s1.mode == MODE_RUNNING);
	assign expire  = running && (rd_data_s1.ticks <= TICK_W'(1));
	assign fire    = expire && (fire_cnt_q < FIRE_W'(MAX_RESULTS));

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = rd_data_s1;
		if (cmd.add_claim) begin
			wr_en         = 1'b1;
			wr_data.mode  = MODE_RUNNING;
			wr_data.ticks = req_q.seconds;
		end else if (cmd.chk_exec && req_q.req_type == REQ_CANCEL
				&& rd_data_s1.mode != MODE_CANCELED && rd_data_s1.mode != MODE_OVER) begin
			wr_en        = 1'b1;
			wr_addr      = id_idx;
			wr_data.mode = MODE_CANCELED;
		end else if (running) begin
			wr_en   = 1'b1;
			wr_addr = idx_s1;
			if (!expire) begin
				wr_data.ticks = rd_data_s1.ticks - TICK_W'(1);
			end else if (fire) begin
				wr_data.mode  = MODE_OVER;
				wr_data.ticks = '0;
			end else begin
				// past the result cap: stays running at zero, fires next tick
				wr_data.ticks = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_comb begin
		emit     = 1'b0;
		emit_rsp = '{status: ST_OK, slot: '0, fired: 1'b0, last: 1'b1};
		if (cmd.add_claim) begin
			emit          = 1'b1;
			emit_rsp.slot = ID_W'(idx_q);
		end else if (cmd.add_full) begin
			emit            = 1'b1;
			emit_rsp.status = ST_FULL;
		end else if (cmd.chk_bad) begin
			emit            = 1'b1;
			emit_rsp.status = ST_INVALID;
		end else if (cmd.chk_exec) begin
			emit = 1'b1;
			if (req_q.req_type == REQ_CANCEL) begin
				if (rd_data_s1.mode == MODE_CANCELED) begin
					emit_rsp.status = ST_CANCELED;
				end else if (rd_data_s1.mode == MODE_OVER) begin
					emit_rsp.status = ST_BUSY;
				end
			end else if (rd_data_s1.mode == MODE_RUNNING) begin
				emit_rsp.status = ST_PENDING;
			end
		end else if (fire && hold_valid_q) begin
			emit           = 1'b1;
			emit_rsp.slot  = ID_W'(hold_slot_q);
			emit_rsp.fired = 1'b1;
			emit_rsp.last  = 1'b0;
		end else if (cmd.tick_flush) begin
			emit = 1'b1;
			if (hold_valid_q) begin
				emit_rsp.slot  = ID_W'(hold_slot_q);
				emit_rsp.fired = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
		if (emit) begin
			rsp_q <= emit_rsp;
		end
		if (fire) begin
			hold_slot_q <= idx_s1;
		end
		idx_s1 <= idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			used_q       <= '0;
			tick_s1      <= 1'b0;
			fire_cnt_q   <= '0;
			hold_valid_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			rsp_valid_q <= emit;
			tick_s1     <= cmd.tick_rd;
			if (cmd.load) begin
				idx_q        <= '0;
				fire_cnt_q   <= '0;
				hold_valid_q <= 1'b0;
			end else begin
				if (cmd.idx_inc) begin
					idx_q <= idx_q + IW'(1);
				end
				if (fire) begin
					fire_cnt_q   <= fire_cnt_q + FIRE_W'(1);
					hold_valid_q <= 1'b1;
				end else if (cmd.tick_flush) begin
					hold_valid_q <= 1'b0;
				end
			end
			if (cmd.add_claim) begin
				used_q[idx_q] <= 1'b1;
			end
			if (cmd.chk_exec && req_q.req_type == REQ_WAIT
					&& rd_data_s1.mode != MODE_RUNNING) begin
				used_q[id_idx] <= 1'b0;
			end
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

	a_fire_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fire_cnt_q <= FIRE_W'(MAX_RESULTS))
		else $error("fire count past result cap");

	a_one_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.chk_read && cmd.tick_rd))
		else $error("two reads issued in one cycle");

	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tick_flush |=> !hold_valid_q)
		else $error("held fired result survived flush");

	a_claim_used: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.add_claim |=> used_q[$past(idx_q)])
		else $error("claimed slot not marked used");

	a_fired_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.fired |-> rsp_q.status == ST_OK)
		else $error("fired result with error status");

endmodule
